// ===== sv/assert_macros.svh =====
// Assertion macros for the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is high.
`define SWM_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define SWM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/swm_pkg.sv =====
// Shared constants for the sliding window maximum block.
// No dependencies.
package swm_pkg;

  // Width and reset value of the window size register.
  localparam int WSIZE_BITS = 7;
  localparam logic [WSIZE_BITS-1:0] WSIZE_RESET = 7'd3;

endpackage

// ===== sv/swm_cell.sv =====
// One cell of the running-maximum chain.
// Uses swm_pkg; instantiated by sliding_window_maximum.
module swm_cell #(
  parameter int INDEX       = 0,
  parameter int SAMPLE_BITS = 32,
  parameter int KW          = 7
) (
  input  logic                          clk,
  input  logic                          shift_en,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic signed [SAMPLE_BITS-1:0] prev_max,
  input  logic        [KW-1:0]          k_eff,
  output logic signed [SAMPLE_BITS-1:0] cur_max,
  output logic        [SAMPLE_BITS-1:0] tap
);
  import swm_pkg::*;

  logic signed [SAMPLE_BITS-1:0] max_next;
  logic                          is_tap;

  // Cell j holds the max of the j+1 newest samples.
  always_comb begin
    if (INDEX == 0) begin
      max_next = sample;
    end else if (sample > prev_max) begin
      max_next = sample;
    end else begin
      max_next = prev_max;
    end
  end

  assign is_tap = (k_eff == KW'(INDEX + 1));
  assign tap    = is_tap ? max_next : '0;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      cur_max <= max_next;
    end
  end

endmodule

// ===== sv/sliding_window_maximum.sv =====
// Top level of the sliding window maximum block.
// Uses swm_pkg and swm_cell.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+------------------------------
//   input    | in_valid / in_stall       | sample, end_of_sequence
//   output   | out_valid / out_stall     | window_max, last_result
//   config   | wr_en                     | wr_data (window_size)
//
// One sample per cycle unless stalled; a result appears in the cycle after its sample.
// Throughput is set by the single output register: the input stalls
// only while a result sits there and the output side stalls it.
// rst (synchronous) clears the count, the output valid and sets the
// window size to 3. Cell contents need no reset.
module sliding_window_maximum #(
  parameter int MAX_WINDOW  = 64,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [SAMPLE_BITS-1:0]     sample,
  input  logic                              end_of_sequence,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [SAMPLE_BITS-1:0]     window_max,
  output logic                              last_result,
  input  logic                              wr_en,
  input  logic [swm_pkg::WSIZE_BITS-1:0]    wr_data
);
  import swm_pkg::*;

  // Count width: must hold MAX_WINDOW and the raw register value.
  localparam int CW = $clog2(MAX_WINDOW + 1);
  localparam int KW = (CW > WSIZE_BITS) ? CW : WSIZE_BITS;

  logic [WSIZE_BITS-1:0] window_size;
  logic [KW-1:0]         ws_ext;
  logic [KW-1:0]         k_eff;
  logic [KW-1:0]         samples_seen;
  logic [KW-1:0]         samples_seen_next;
  logic                  accept;
  logic                  has_result;

  logic signed [SAMPLE_BITS-1:0] cell_max [MAX_WINDOW];
  logic        [SAMPLE_BITS-1:0] cell_tap [MAX_WINDOW];
  logic        [SAMPLE_BITS-1:0] tap_sel;

  // Window size above MAX_WINDOW acts as MAX_WINDOW.
  assign ws_ext = KW'(window_size);
  assign k_eff  = (ws_ext > KW'(MAX_WINDOW)) ? KW'(MAX_WINDOW) : ws_ext;

  // Stall only while the held result is itself stalled.
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  // Count saturates at MAX_WINDOW.
  assign samples_seen_next = (samples_seen < KW'(MAX_WINDOW)) ?
                             samples_seen + KW'(1) : samples_seen;
  assign has_result = (k_eff != '0) && (samples_seen_next >= k_eff);

  // Cell chain: each cell but the first takes its neighbor's running max and the new
  // sample on each transfer. Stale cells from an earlier sequence are
  // never tapped before k samples of the new one have passed over them.
  for (genvar j = 0; j < MAX_WINDOW; j++) begin : g_cell
    logic signed [SAMPLE_BITS-1:0] prev;
    if (j == 0) begin : g_head
      assign prev = sample;
    end else begin : g_body
      assign prev = cell_max[j-1];
    end
    swm_cell #(
      .INDEX      (j),
      .SAMPLE_BITS(SAMPLE_BITS),
      .KW         (KW)
    ) u_cell (
      .clk     (clk),
      .shift_en(accept),
      .sample  (sample),
      .prev_max(prev),
      .k_eff   (k_eff),
      .cur_max (cell_max[j]),
      .tap     (cell_tap[j])
    );
  end

  // At most one cell taps (the one at k-1); OR the gated values.
  always_comb begin
    tap_sel = '0;
    for (int j = 0; j < MAX_WINDOW; j++) begin
      tap_sel = tap_sel | cell_tap[j];
    end
  end

  // Config register and sequence count.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size  <= WSIZE_RESET;
      samples_seen <= '0;
    end else begin
      if (wr_en) begin
        window_size <= wr_data;
      end
      if (accept) begin
        samples_seen <= end_of_sequence ? '0 : samples_seen_next;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= has_result;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && has_result) begin
      window_max  <= tap_sel;
      last_result <= end_of_sequence;
    end
  end

endmodule

// ===== sv/swm_checker.sv =====
// Port-level checks for sliding_window_maximum, bound to the top level.
// Uses swm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module swm_checker #(
  parameter int SAMPLE_BITS = 32
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic [SAMPLE_BITS-1:0]         sample,
  input logic                           end_of_sequence,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [SAMPLE_BITS-1:0]         window_max,
  input logic                           last_result,
  input logic                           wr_en,
  input logic [swm_pkg::WSIZE_BITS-1:0] wr_data
);
  import swm_pkg::*;

  logic [WSIZE_BITS-1:0] ws_mirror;

  // Shadow copy of the window size register.
  always_ff @(posedge clk) begin
    if (rst) begin
      ws_mirror <= WSIZE_RESET;
    end else if (wr_en) begin
      ws_mirror <= wr_data;
    end
  end

  `SWM_ASSERT(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(window_max) && $stable(last_result), "stalled result changed")
  `SWM_ASSERT(a_stall_cause, clk, rst, in_stall |-> out_valid && out_stall, "input stalled without a held result")
  `SWM_ASSERT_ALWAYS(a_rst_clear, clk, rst |=> !out_valid, "result valid after reset")
  `SWM_ASSERT(a_win_one, clk, rst, in_valid && !in_stall && ws_mirror == WSIZE_BITS'(1) |=> out_valid && window_max == $past(sample) && last_result == $past(end_of_sequence), "window of one must echo the sample")

endmodule

bind sliding_window_maximum swm_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_swm_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .sample         (sample),
  .end_of_sequence(end_of_sequence),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .window_max     (window_max),
  .last_result    (last_result),
  .wr_en          (wr_en),
  .wr_data        (wr_data)
);

// ===== verif/tb_sliding_window_maximum.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for sliding_window_maximum: directed cases, then random samples, sequences, sizes and stalls.
// Depends on swm_pkg and the sliding_window_maximum RTL; nothing else.
module tb_sliding_window_maximum;

  import swm_pkg::*;

  localparam int WINDOW_DEPTH = 64;
  localparam int SAMPLE_W     = 32;
  localparam int RANDOM_ITEMS = 1000;
  // No transfer of any kind for this many cycles means the block is hung.
  localparam int HANG_LIMIT   = 4000;
  // Result shows up in the cycle after its sample; this spare margin covers it.
  localparam int SETTLE_CYCLES = 4;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [WSIZE_BITS-1:0]      wsize_t;

  typedef struct {
    sample_t max_val;
    logic    last;
  } max_result_t;

  // Tracks the window contents and the queue of window maxima still owed by the block.
  class window_max_scoreboard;
    sample_t      history[WINDOW_DEPTH];
    int unsigned  seq_count;
    wsize_t       window_size;
    max_result_t  owed_q[$];
    int           mismatches;

    function new();
      foreach (history[i]) history[i] = '0;
      seq_count   = 0;
      window_size = WSIZE_RESET;
      mismatches  = 0;
    endfunction

    function void set_window(wsize_t v);
      window_size = v;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    // One accepted sample: shift it in, maybe owe a maximum.
    function void note_sample(sample_t s, logic eos);
      int unsigned span;
      sample_t     best;
      max_result_t r;
      for (int i = WINDOW_DEPTH - 1; i > 0; i--) history[i] = history[i-1];
      history[0] = s;
      if (seq_count < WINDOW_DEPTH) seq_count++;
      span = (window_size > WINDOW_DEPTH) ? WINDOW_DEPTH : window_size;
      if (span != 0 && seq_count >= span) begin
        best = history[0];
        for (int i = 1; i < span; i++) if (history[i] > best) best = history[i];
        r.max_val = best;
        r.last    = eos;
        owed_q.push_back(r);
      end
      if (eos) seq_count = 0;
    endfunction

    function void flag(string what, max_result_t exp_r, sample_t got_max, logic got_last);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t %s: expected max %0d last %0b, got max %0d last %0b", $realtime, what,
                 exp_r.max_val, exp_r.last, got_max, got_last);
    endfunction

    // One accepted result: compare against the oldest owed maximum.
    function void check_result(sample_t got_max, logic got_last);
      max_result_t exp_r;
      if (owed_q.size() == 0) begin
        exp_r.max_val = 'x;
        exp_r.last    = 1'bx;
        flag("unexpected result", exp_r, got_max, got_last);
        return;
      end
      exp_r = owed_q.pop_front();
      if (exp_r.max_val !== got_max || exp_r.last !== got_last)
        flag("result mismatch", exp_r, got_max, got_last);
    endfunction
  endclass

  logic    clk;
  logic    rst;
  logic    in_valid;
  logic    in_stall;
  sample_t sample;
  logic    end_of_sequence;
  logic    out_valid;
  logic    out_stall;
  sample_t window_max;
  logic    last_result;
  logic    wr_en;
  wsize_t  wr_data;

  // When set, the sender drives back to back and the sink never stalls.
  logic    steady;
  int      idle_cycles = 0;

  window_max_scoreboard sb = new();

  sliding_window_maximum #(
    .MAX_WINDOW (WINDOW_DEPTH),
    .SAMPLE_BITS(SAMPLE_W)
  ) uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .sample         (sample),
    .end_of_sequence(end_of_sequence),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .window_max     (window_max),
    .last_result    (last_result),
    .wr_en          (wr_en),
    .wr_data        (wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Output checker: every result transfer is matched against the oldest owed maximum.
  // All DUT and TB drives are nonblocking, so reads here see pre-edge values.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(window_max, last_result);
  end

  // Hang watchdog: counts cycles without any transfer on any channel.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || wr_en) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= HANG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Sink back-pressure: runs of free cycles broken by stalls, mostly short, now and then long.
  // No run is empty, so out_stall gets one update per edge.
  initial begin : sink_stall
    int run_len;
    int hold_len;
    out_stall = 1'b0;
    forever begin
      run_len = $urandom_range(1, 12);
      out_stall <= 1'b0;
      repeat (run_len) @(posedge clk);
      if (!steady) begin
        hold_len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        out_stall <= 1'b1;
        repeat (hold_len) @(posedge clk);
      end
    end
  end

  // Sender gap: mostly none, sometimes short, rarely a long pause.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 19);
    if (steady || roll < 12) return 0;
    if (roll < 19) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Sample mix: full random, the two extremes, a band just above the minimum, and a narrow band so ties are common.
  function automatic sample_t pick_sample();
    case ($urandom_range(0, 9))
      0:       return sample_t'(32'h8000_0000);
      1:       return sample_t'(32'h7FFF_FFFF);
      2, 3:    return sample_t'($signed($urandom_range(0, 15)) - 8);
      4:       return sample_t'(32'h8000_0000 + $urandom_range(0, 3));
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Drive one sample until the block takes it, then log it and maybe back off.
  // Valid stays high into the next item when there is no gap.
  task automatic push_sample(input sample_t s, input logic eos);
    int gap;
    in_valid        <= 1'b1;
    sample          <= s;
    end_of_sequence <= eos;
    do @(posedge clk); while (!(in_valid && !in_stall));
    sb.note_sample(s, eos);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop sending and let every owed result drain, plus a margin for
  // samples that owe nothing but may still be in flight.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Window size writes only happen with the block drained.
  task automatic write_window(input wsize_t v);
    drain();
    wr_en   <= 1'b1;
    wr_data <= v;
    @(posedge clk);
    wr_en   <= 1'b0;
    sb.set_window(v);
  endtask

  task automatic push_run(input sample_t vals[$], input logic close_it);
    foreach (vals[i]) push_sample(vals[i], close_it && (i == vals.size() - 1));
  endtask

  initial begin : stimulus
    int      sent;
    int      seq_n;
    int      seq_len;
    int      span;
    logic    close_it;
    wsize_t  w;
    in_valid        = 1'b0;
    sample          = '0;
    end_of_sequence = 1'b0;
    wr_en           = 1'b0;
    wr_data         = '0;
    steady          = 1'b0;
    rst             = 1'b1;
    sent            = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed part ---
    // Reset window of three: both extremes, zero, minus one, extremes back to back.
    push_run('{sample_t'(32'h8000_0000), sample_t'(32'h7FFF_FFFF), sample_t'(0),
               sample_t'(-1), sample_t'(32'h8000_0000), sample_t'(-1)}, 1'b1);
    // Sequence shorter than the window: no results at all.
    push_run('{sample_t'(1), sample_t'(2)}, 1'b1);
    // Window of one passes samples straight through.
    write_window(wsize_t'(1));
    push_run('{sample_t'(7), sample_t'(-7)}, 1'b1);
    // Window of zero: silent, but end of sequence still clears the count.
    write_window(wsize_t'(0));
    push_run('{sample_t'(3), sample_t'(4)}, 1'b1);
    // Ties: max is the shared value.
    write_window(wsize_t'(2));
    push_run('{sample_t'(9), sample_t'(9), sample_t'(9)}, 1'b1);
    // Size changed mid-sequence: new size measured against samples already held.
    write_window(wsize_t'(4));
    push_run('{sample_t'(1), sample_t'(2), sample_t'(3)}, 1'b0);
    write_window(wsize_t'(2));
    push_run('{sample_t'(0), sample_t'(5)}, 1'b1);

    // --- random part ---
    // Each phase: one window size, then a few sequences. Most are long enough to
    // give results; some are too short, some run past saturation, and some are
    // left open so the next size lands mid-sequence.
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 19))
        0, 1:          w = wsize_t'(0);
        2, 3:          w = wsize_t'(1);
        4, 5:          w = wsize_t'(WINDOW_DEPTH);
        6:             w = '1;
        7:             w = wsize_t'($urandom_range(WINDOW_DEPTH + 1, 126));
        8, 9, 10, 11:  w = wsize_t'($urandom_range(9, WINDOW_DEPTH - 1));
        default:       w = wsize_t'($urandom_range(2, 8));
      endcase
      write_window(w);
      steady = ($urandom_range(0, 3) == 0);
      span   = (w > WINDOW_DEPTH) ? WINDOW_DEPTH : w;
      seq_n  = $urandom_range(1, 4);
      repeat (seq_n) begin
        case ($urandom_range(0, 9))
          0:       seq_len = $urandom_range(1, 3);
          1:       seq_len = span + $urandom_range(40, 90);
          default: seq_len = span + $urandom_range(0, 12);
        endcase
        if (seq_len < 1) seq_len = 1;
        close_it = ($urandom_range(0, 7) != 0);
        for (int i = 0; i < seq_len; i++) begin
          push_sample(pick_sample(), close_it && (i == seq_len - 1));
          sent++;
        end
      end
    end

    // Wind down: everything owed must arrive, then a quiet spell for strays.
    steady = 1'b0;
    drain();
    repeat (4 * SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/swm_pkg.sv
sv/swm_cell.sv
sv/sliding_window_maximum.sv
sv/swm_checker.sv
verif/tb_sliding_window_maximum.sv
